// ===== design/multilevel_feedback_scheduler_core_assert.svh =====
// assertion macros for the multilevel feedback scheduler
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_CORE_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MFS_ASSERT_ALWAYS(lbl, cond, msg)
`define MFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/mfs_pkg.sv =====
// package: shared constants and types of the multilevel feedback scheduler
`default_nettype none
package mfs_pkg;
  localparam int MAX_PROCS_DEF = 16;
  localparam logic [7:0] QUANTUM_DEF = 8'd10;
  localparam logic [7:0] IO_WAIT_DEF = 8'd20;
  localparam logic [5:0] AGING_LIMIT_DEF = 6'd30;

  localparam logic [1:0] CFG_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_IO_WAIT = 2'd1;
  localparam logic [1:0] CFG_AGING_LIMIT = 2'd2;

  localparam logic [1:0] Q_RR = 2'd0;
  localparam logic [1:0] Q_FCFS = 2'd1;
  localparam logic [1:0] Q_IO = 2'd2;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ARRIVE = 1'b1;

  typedef struct packed {
    logic [9:0]  burst;
    logic [7:0]  ios;
    logic [9:0]  prog;
    logic [17:0] exec;
    logic [5:0]  wait_cnt;
  } proc_rec_t;
endpackage
`default_nettype wire

// ===== design/multilevel_feedback_scheduler_core.sv =====
// top level: tick-driven two-level feedback scheduler with memory-held state
// arrival request: handled in S_IDLE, no result; requests of either kind are taken only in S_IDLE
// tick request: S_HEAD, S_PROC, S_RUN, then the aging walk over the fcfs entries left after the run,
// then S_IO (S_IO_WR when an i/o entry returns) and S_DONE; S_HEAD goes to the walk when nothing ran
// each fcfs entry walks S_AGE_RD, S_AGE_TB, S_AGE_UPD; S_DONE holds while the last result is unread
// reset (rst_n low, synchronous): queues empty, timers reset, registers to defaults
`default_nettype none
`include "multilevel_feedback_scheduler_core_assert.svh"
module multilevel_feedback_scheduler_core #(
  parameter int MAX_PROCS = mfs_pkg::MAX_PROCS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_command,
  input  wire logic [4:0] in_process_id,
  input  wire logic [9:0] in_burst_length,
  input  wire logic [7:0] in_io_count,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [4:0] out_cpu_process,
  output logic            out_finished,
  output logic            out_sent_to_io,
  output logic            out_all_idle,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);
  // widths that follow from the process count
  localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int XW = SW + 2;
  localparam int QD = 3 * MAX_PROCS;
  localparam int AW = $clog2(QD);
  localparam int TW = $clog2(MAX_PROCS > 1 ? MAX_PROCS : 2);
  localparam int RW = $bits(mfs_pkg::proc_rec_t);

  // sequencer codes
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_HEAD    = 4'd1;
  localparam logic [3:0] S_PROC    = 4'd2;
  localparam logic [3:0] S_RUN     = 4'd3;
  localparam logic [3:0] S_AGE_RD  = 4'd4;
  localparam logic [3:0] S_AGE_TB  = 4'd5;
  localparam logic [3:0] S_AGE_UPD = 4'd6;
  localparam logic [3:0] S_IO      = 4'd7;
  localparam logic [3:0] S_IO_WR   = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  // circular slot add, offset never exceeds the queue depth
  function automatic logic [SW-1:0] wrap_add(input logic [SW-1:0] b, input logic [CW-1:0] o);
    logic [XW-1:0] s;
    s = XW'(b) + XW'(o);
    if (s >= XW'(MAX_PROCS)) begin
      s = s - XW'(MAX_PROCS);
    end
    return SW'(s);
  endfunction

  // the three queues share one ram, one region each
  function automatic logic [AW-1:0] qaddr(input logic [1:0] qs, input logic [SW-1:0] slot);
    logic [AW-1:0] a;
    case (qs)
      mfs_pkg::Q_FCFS: a = AW'(MAX_PROCS) + AW'(slot);
      mfs_pkg::Q_IO:   a = AW'(2 * MAX_PROCS) + AW'(slot);
      default:         a = AW'(slot);
    endcase
    return a;
  endfunction

  logic [3:0]       state_r, state_nxt;
  logic [SW-1:0]    cur_p_r, cur_p_nxt;
  logic             run_rr_r, run_rr_nxt;
  logic             ran_fcfs_r, ran_fcfs_nxt;
  logic [4:0]       ran_id_r, ran_id_nxt;
  logic             fin_r, fin_nxt;
  logic             toio_r, toio_nxt;
  logic [CW-1:0]    age_n_r, age_n_nxt;
  logic [CW-1:0]    age_i_r, age_i_nxt;
  logic [CW-1:0]    age_k_r, age_k_nxt;
  logic [SW-1:0]    rr_head_r, rr_head_nxt;
  logic [SW-1:0]    fcfs_head_r, fcfs_head_nxt;
  logic [SW-1:0]    io_head_r, io_head_nxt;
  logic [CW-1:0]    rr_cnt_r, rr_cnt_nxt;
  logic [CW-1:0]    fcfs_cnt_r, fcfs_cnt_nxt;
  logic [CW-1:0]    io_cnt_r, io_cnt_nxt;
  logic [7:0]       qt_r, qt_nxt;
  logic signed [8:0] io_timer_r, io_timer_nxt;
  logic [MAX_PROCS-1:0] active_r, active_nxt;
  logic [7:0]       quantum_r, quantum_nxt;
  logic [7:0]       io_wait_r, io_wait_nxt;
  logic [5:0]       aging_r, aging_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [4:0]       out_cpu_r, out_cpu_nxt;
  logic             out_fin_r, out_fin_nxt;
  logic             out_toio_r, out_toio_nxt;
  logic             out_idle_r, out_idle_nxt;

  // ram ports
  logic             q_we;
  logic [AW-1:0]    q_waddr, q_raddr;
  logic [SW-1:0]    q_wdata, q_rdata;
  logic             t_we;
  logic [TW-1:0]    t_waddr, t_raddr;
  mfs_pkg::proc_rec_t t_wdata, t_rdata;

  // working values
  logic             arrive_ok;
  logic [SW-1:0]    arr_p;
  mfs_pkg::proc_rec_t rec;
  logic [18:0]      need;
  logic [9:0]       prog1;
  logic [17:0]      exec1;
  logic             done_w, brk_w;
  logic [7:0]       qt1;
  logic [5:0]       wait1;
  logic             promote;
  logic signed [8:0] tmr1;
  logic [CW+1:0]    q_total;

  mfs_ram #(.WIDTH(SW), .DEPTH(QD)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  mfs_ram #(.WIDTH(RW), .DEPTH(MAX_PROCS)) u_proc_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_cpu_process = out_cpu_r;
  assign out_finished    = out_fin_r;
  assign out_sent_to_io  = out_toio_r;
  assign out_all_idle    = out_idle_r;

  // arrival checks: id in range here; the not-already-queued check uses active_r at the arrival
  assign arrive_ok = ({4'b0, in_process_id} != 9'd0) &&
                     ({4'b0, in_process_id} <= 9'(MAX_PROCS));
  assign arr_p = SW'({4'b0, in_process_id} - 9'd1);

  // one cpu unit on the record just read back
  assign rec    = t_rdata;
  assign need   = 19'({1'b0, rec.ios} + 9'd1) * 19'(rec.burst);
  assign prog1  = rec.prog + 10'd1;
  assign exec1  = rec.exec + 18'd1;
  assign done_w = (19'(exec1) >= need);
  assign brk_w  = !done_w && (prog1 >= rec.burst);
  assign qt1    = qt_r + 8'd1;

  // aging of one fcfs entry; the first entry walked after an fcfs run has its wait cleared
  always_comb begin
    if ((age_i_r == '0) && ran_fcfs_r) begin
      wait1 = 6'd0;
    end else if (rec.wait_cnt < 6'd63) begin
      wait1 = rec.wait_cnt + 6'd1;
    end else begin
      wait1 = rec.wait_cnt;
    end
  end
  assign promote = ({1'b0, wait1} == ({1'b0, aging_r} + 7'd1));

  // io timer steps toward io_wait and holds at its ceiling
  assign tmr1 = (io_timer_r < 9'sd255) ? (io_timer_r + 9'sd1) : io_timer_r;

  assign q_total = (CW+2)'(rr_cnt_r) + (CW+2)'(fcfs_cnt_r) + (CW+2)'(io_cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cur_p_nxt     = cur_p_r;
    run_rr_nxt    = run_rr_r;
    ran_fcfs_nxt  = ran_fcfs_r;
    ran_id_nxt    = ran_id_r;
    fin_nxt       = fin_r;
    toio_nxt      = toio_r;
    age_n_nxt     = age_n_r;
    age_i_nxt     = age_i_r;
    age_k_nxt     = age_k_r;
    rr_head_nxt   = rr_head_r;
    fcfs_head_nxt = fcfs_head_r;
    io_head_nxt   = io_head_r;
    rr_cnt_nxt    = rr_cnt_r;
    fcfs_cnt_nxt  = fcfs_cnt_r;
    io_cnt_nxt    = io_cnt_r;
    qt_nxt        = qt_r;
    io_timer_nxt  = io_timer_r;
    active_nxt    = active_r;
    quantum_nxt   = quantum_r;
    io_wait_nxt   = io_wait_r;
    aging_nxt     = aging_r;
    out_valid_nxt = out_valid_r;
    out_cpu_nxt   = out_cpu_r;
    out_fin_nxt   = out_fin_r;
    out_toio_nxt  = out_toio_r;
    out_idle_nxt  = out_idle_r;
    q_we          = 1'b0;
    q_waddr       = '0;
    q_wdata       = '0;
    q_raddr       = '0;
    t_we          = 1'b0;
    t_waddr       = '0;
    t_wdata       = rec;
    t_raddr       = '0;

    // result register drains independently of the sequencer
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // configuration decoder
    if (cfg_we) begin
      unique case (cfg_index)
        mfs_pkg::CFG_QUANTUM:     quantum_nxt = cfg_wdata;
        mfs_pkg::CFG_IO_WAIT:     io_wait_nxt = cfg_wdata;
        mfs_pkg::CFG_AGING_LIMIT: aging_nxt   = cfg_wdata[5:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_command == mfs_pkg::CMD_ARRIVE) begin
            // new process: fresh record, joins the rr tail
            if (arrive_ok && !active_r[arr_p]) begin
              active_nxt[arr_p] = 1'b1;
              t_we              = 1'b1;
              t_waddr           = TW'(arr_p);
              t_wdata.burst     = in_burst_length;
              t_wdata.ios       = in_io_count;
              t_wdata.prog      = '0;
              t_wdata.exec      = '0;
              t_wdata.wait_cnt  = '0;
              q_we              = 1'b1;
              q_waddr           = qaddr(mfs_pkg::Q_RR, wrap_add(rr_head_r, rr_cnt_r));
              q_wdata           = arr_p;
              rr_cnt_nxt        = rr_cnt_r + CW'(1);
            end
          end else begin
            fin_nxt      = 1'b0;
            toio_nxt     = 1'b0;
            ran_id_nxt   = '0;
            ran_fcfs_nxt = 1'b0;
            age_i_nxt    = '0;
            age_k_nxt    = '0;
            state_nxt    = S_HEAD;
          end
        end
      end

      S_HEAD: begin
        // rr head has priority, fcfs head only when rr is empty
        if (rr_cnt_r != '0) begin
          run_rr_nxt = 1'b1;
          q_raddr    = qaddr(mfs_pkg::Q_RR, rr_head_r);
          state_nxt  = S_PROC;
        end else if (fcfs_cnt_r != '0) begin
          run_rr_nxt   = 1'b0;
          ran_fcfs_nxt = 1'b1;
          q_raddr      = qaddr(mfs_pkg::Q_FCFS, fcfs_head_r);
          state_nxt    = S_PROC;
        end else begin
          age_n_nxt = fcfs_cnt_r;
          state_nxt = S_AGE_RD;
        end
      end

      S_PROC: begin
        cur_p_nxt = q_rdata;
        t_raddr   = TW'(q_rdata);
        state_nxt = S_RUN;
      end

      S_RUN: begin
        t_we          = 1'b1;
        t_waddr       = TW'(cur_p_r);
        t_wdata.prog  = brk_w ? 10'd0 : prog1;
        t_wdata.exec  = exec1;
        ran_id_nxt    = 5'(9'(cur_p_r) + 9'd1);
        if (done_w) begin
          active_nxt[cur_p_r] = 1'b0;
          fin_nxt             = 1'b1;
        end
        if (brk_w) begin
          // burst over: to the io tail
          toio_nxt   = 1'b1;
          q_we       = 1'b1;
          q_waddr    = qaddr(mfs_pkg::Q_IO, wrap_add(io_head_r, io_cnt_r));
          q_wdata    = cur_p_r;
          io_cnt_nxt = io_cnt_r + CW'(1);
        end
        if (run_rr_r) begin
          qt_nxt = qt1;
          if (done_w || brk_w || (qt1 == quantum_r)) begin
            qt_nxt      = 8'd0;
            rr_head_nxt = wrap_add(rr_head_r, CW'(1));
            rr_cnt_nxt  = rr_cnt_r - CW'(1);
          end
          if (!done_w && !brk_w && (qt1 == quantum_r)) begin
            // quantum used up: demote to the fcfs tail
            q_we         = 1'b1;
            q_waddr      = qaddr(mfs_pkg::Q_FCFS, wrap_add(fcfs_head_r, fcfs_cnt_r));
            q_wdata      = cur_p_r;
            fcfs_cnt_nxt = fcfs_cnt_r + CW'(1);
          end
        end else if (done_w || brk_w) begin
          fcfs_head_nxt = wrap_add(fcfs_head_r, CW'(1));
          fcfs_cnt_nxt  = fcfs_cnt_r - CW'(1);
        end
        age_n_nxt = fcfs_cnt_nxt;
        state_nxt = S_AGE_RD;
      end

      S_AGE_RD: begin
        if (age_i_r == age_n_r) begin
          state_nxt = S_IO;
        end else begin
          q_raddr   = qaddr(mfs_pkg::Q_FCFS, wrap_add(fcfs_head_r, age_i_r));
          state_nxt = S_AGE_TB;
        end
      end

      S_AGE_TB: begin
        cur_p_nxt = q_rdata;
        t_raddr   = TW'(q_rdata);
        state_nxt = S_AGE_UPD;
      end

      S_AGE_UPD: begin
        t_we             = 1'b1;
        t_waddr          = TW'(cur_p_r);
        t_wdata.wait_cnt = promote ? 6'd0 : wait1;
        q_we             = 1'b1;
        q_wdata          = cur_p_r;
        if (promote) begin
          // aged out: back to the rr tail
          q_waddr      = qaddr(mfs_pkg::Q_RR, wrap_add(rr_head_r, rr_cnt_r));
          rr_cnt_nxt   = rr_cnt_r + CW'(1);
          fcfs_cnt_nxt = fcfs_cnt_r - CW'(1);
        end else begin
          // kept entries are packed down from the head in order
          q_waddr   = qaddr(mfs_pkg::Q_FCFS, wrap_add(fcfs_head_r, age_k_r));
          age_k_nxt = age_k_r + CW'(1);
        end
        age_i_nxt = age_i_r + CW'(1);
        state_nxt = S_AGE_RD;
      end

      S_IO: begin
        if (io_cnt_r != '0) begin
          if (tmr1 == $signed({1'b0, io_wait_r})) begin
            q_raddr   = qaddr(mfs_pkg::Q_IO, io_head_r);
            state_nxt = S_IO_WR;
          end else begin
            io_timer_nxt = tmr1;
            state_nxt    = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_IO_WR: begin
        // io head returns to rr; timer restarts, steps to zero if io still holds work
        q_we         = 1'b1;
        q_waddr      = qaddr(mfs_pkg::Q_RR, wrap_add(rr_head_r, rr_cnt_r));
        q_wdata      = q_rdata;
        rr_cnt_nxt   = rr_cnt_r + CW'(1);
        io_head_nxt  = wrap_add(io_head_r, CW'(1));
        io_cnt_nxt   = io_cnt_r - CW'(1);
        io_timer_nxt = (io_cnt_r > CW'(1)) ? 9'sd0 : -9'sd1;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cpu_nxt   = ran_id_r;
          out_fin_nxt   = fin_r;
          out_toio_nxt  = toio_r;
          out_idle_nxt  = (rr_cnt_r == '0) && (fcfs_cnt_r == '0) && (io_cnt_r == '0);
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_rr_r    <= 1'b0;
      ran_fcfs_r  <= 1'b0;
      fin_r       <= 1'b0;
      toio_r      <= 1'b0;
      age_n_r     <= '0;
      age_i_r     <= '0;
      age_k_r     <= '0;
      rr_head_r   <= '0;
      fcfs_head_r <= '0;
      io_head_r   <= '0;
      rr_cnt_r    <= '0;
      fcfs_cnt_r  <= '0;
      io_cnt_r    <= '0;
      qt_r        <= '0;
      io_timer_r  <= -9'sd1;
      active_r    <= '0;
      quantum_r   <= mfs_pkg::QUANTUM_DEF;
      io_wait_r   <= mfs_pkg::IO_WAIT_DEF;
      aging_r     <= mfs_pkg::AGING_LIMIT_DEF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      run_rr_r    <= run_rr_nxt;
      ran_fcfs_r  <= ran_fcfs_nxt;
      fin_r       <= fin_nxt;
      toio_r      <= toio_nxt;
      age_n_r     <= age_n_nxt;
      age_i_r     <= age_i_nxt;
      age_k_r     <= age_k_nxt;
      rr_head_r   <= rr_head_nxt;
      fcfs_head_r <= fcfs_head_nxt;
      io_head_r   <= io_head_nxt;
      rr_cnt_r    <= rr_cnt_nxt;
      fcfs_cnt_r  <= fcfs_cnt_nxt;
      io_cnt_r    <= io_cnt_nxt;
      qt_r        <= qt_nxt;
      io_timer_r  <= io_timer_nxt;
      active_r    <= active_nxt;
      quantum_r   <= quantum_nxt;
      io_wait_r   <= io_wait_nxt;
      aging_r     <= aging_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_p_r    <= cur_p_nxt;
    ran_id_r   <= ran_id_nxt;
    out_cpu_r  <= out_cpu_nxt;
    out_fin_r  <= out_fin_nxt;
    out_toio_r <= out_toio_nxt;
    out_idle_r <= out_idle_nxt;
  end

  // every live process sits in exactly one queue
  `MFS_ASSERT_ALWAYS(a_active_count, $countones(active_r) == int'(q_total), "active vs queue count")
  // io timer is parked whenever the io queue is empty
  `MFS_ASSERT_ALWAYS(a_io_timer_idle, (io_cnt_r != '0) || (io_timer_r == -9'sd1), "io timer not idle")
  // a held result is not dropped
  `MFS_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ready, out_valid_r, "result dropped")
endmodule
`default_nettype wire

// ===== design/mfs_ram.sv =====
// generic single-write, single-read ram with registered read
`default_nettype none
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== tb/multilevel_feedback_scheduler_core_tb.sv =====
// testbench for the multilevel feedback scheduler core: directed and random requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module multilevel_feedback_scheduler_core_tb;
  localparam int NPROC = mfs_pkg::MAX_PROCS_DEF;
  localparam int IDLE_LIMIT = 3000;  // cycles with no request or result accepted
  localparam int SETTLE = 100;       // settle time after the last result, above the longest tick

  typedef struct {
    logic       cmd;
    logic [4:0] pid;
    logic [9:0] burst;
    logic [7:0] ios;
  } sched_req_t;

  typedef struct {
    logic [4:0] cpu;
    logic       fin;
    logic       to_io;
    logic       idle;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = mfs_pkg::CMD_TICK;
  logic [4:0] in_process_id = '0;
  logic [9:0] in_burst_length = '0;
  logic [7:0] in_io_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [4:0] out_cpu_process;
  logic out_finished;
  logic out_sent_to_io;
  logic out_all_idle;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = mfs_pkg::CFG_QUANTUM;
  logic [7:0] cfg_wdata = '0;

  multilevel_feedback_scheduler_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_process_id(in_process_id), .in_burst_length(in_burst_length),
    .in_io_count(in_io_count),
    .out_valid(out_valid), .out_ready(out_ready), .out_cpu_process(out_cpu_process),
    .out_finished(out_finished), .out_sent_to_io(out_sent_to_io),
    .out_all_idle(out_all_idle),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  logic [7:0]  quantum_q, io_wait_q;
  logic [5:0]  aging_q;
  logic [9:0]  burst_len [NPROC];
  logic [7:0]  io_cnt [NPROC];
  logic [9:0]  progress [NPROC];
  logic [17:0] executed [NPROC];
  logic [5:0]  fcfs_age [NPROC];
  bit          busy_id [NPROC];
  int          rr_q[$], fcfs_q[$], io_q[$];
  logic [7:0]  slice_cnt;
  int          io_clock;

  sched_req_t   pending_reqs[$];
  tick_result_t expected_ticks[$];
  int errors = 0;
  int ticks_done = 0, arrivals_done = 0, finishes_seen = 0, io_sends_seen = 0, idle_seen = 0;
  bit hold_sender = 1'b0;

  task automatic report(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  // one cpu unit for process p: 1 done, 2 burst over, 0 otherwise
  function automatic int run_one_unit(input int p);
    int need;
    need = (int'(io_cnt[p]) + 1) * int'(burst_len[p]);
    progress[p] = progress[p] + 10'd1;
    executed[p] = executed[p] + 18'd1;
    if (int'(executed[p]) >= need) begin
      busy_id[p] = 1'b0;
      return 1;
    end
    if (progress[p] >= burst_len[p]) begin
      progress[p] = '0;
      return 2;
    end
    return 0;
  endfunction

  task automatic predict_request(input sched_req_t r);
    tick_result_t res;
    int p, outcome, n, id;
    bit ran_fcfs;
    res = '{cpu: '0, fin: 1'b0, to_io: 1'b0, idle: 1'b0};
    ran_fcfs = 1'b0;
    if (r.cmd == mfs_pkg::CMD_ARRIVE) begin
      arrivals_done++;
      id = int'(r.pid);
      // bad ids and ids still queued are dropped
      if (id == 0 || id > NPROC) return;
      p = id - 1;
      if (busy_id[p]) return;
      busy_id[p] = 1'b1;
      burst_len[p] = r.burst;
      io_cnt[p] = r.ios;
      progress[p] = '0;
      executed[p] = '0;
      fcfs_age[p] = '0;
      rr_q.insert(rr_q.size(), p);
      return;
    end
    ticks_done++;
    if (rr_q.size() > 0) begin
      p = rr_q[0];
      outcome = run_one_unit(p);
      res.cpu = 5'(p + 1);
      slice_cnt = slice_cnt + 8'd1;
      if (outcome == 1) begin
        slice_cnt = '0;
        void'(rr_q.pop_front());
        res.fin = 1'b1;
      end else if (outcome == 2) begin
        slice_cnt = '0;
        p = rr_q.pop_front();
        io_q.insert(io_q.size(), p);
        res.to_io = 1'b1;
      end else if (slice_cnt == quantum_q) begin
        // quantum used up: demote
        slice_cnt = '0;
        p = rr_q.pop_front();
        fcfs_q.insert(fcfs_q.size(), p);
      end
    end else if (fcfs_q.size() > 0) begin
      p = fcfs_q[0];
      outcome = run_one_unit(p);
      res.cpu = 5'(p + 1);
      ran_fcfs = 1'b1;
      if (outcome == 1) begin
        void'(fcfs_q.pop_front());
        res.fin = 1'b1;
      end else if (outcome == 2) begin
        p = fcfs_q.pop_front();
        io_q.insert(io_q.size(), p);
        res.to_io = 1'b1;
      end
    end
    // aging walk; the front after an fcfs run gets its wait cleared
    n = fcfs_q.size();
    for (int i = 0; i < n; i++) begin
      p = fcfs_q.pop_front();
      if (i == 0 && ran_fcfs) fcfs_age[p] = '0;
      else if (fcfs_age[p] < 6'd63) fcfs_age[p] = fcfs_age[p] + 6'd1;
      if (int'(fcfs_age[p]) == int'(aging_q) + 1) begin
        fcfs_age[p] = '0;
        rr_q.insert(rr_q.size(), p);
      end else begin
        fcfs_q.insert(fcfs_q.size(), p);
      end
    end
    if (io_q.size() > 0) begin
      if (io_clock < 255) io_clock++;
      if (io_clock == int'(io_wait_q)) begin
        io_clock = -1;
        p = io_q.pop_front();
        rr_q.insert(rr_q.size(), p);
        if (io_q.size() > 0) io_clock++;
      end
    end
    res.idle = (rr_q.size() == 0 && fcfs_q.size() == 0 && io_q.size() == 0);
    expected_ticks.insert(expected_ticks.size(), res);
  endtask

  // mostly no gap, some short, a few long; calm stretches come from the mode bit
  bit calm = 1'b0;
  function automatic int pick_gap();
    int k;
    k = $urandom_range(99);
    if (calm || k < 60) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(299) == 0) calm <= ~calm;
  end

  // driver: feeds requests from the pending queue with random gaps
  int gap_left = 0;
  always @(posedge clk) begin
    sched_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        r = '{cmd: in_command, pid: in_process_id, burst: in_burst_length, ios: in_io_count};
        predict_request(r);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          r = pending_reqs.pop_front();
          in_command <= r.cmd;
          in_process_id <= r.pid;
          in_burst_length <= r.burst;
          in_io_count <= r.ios;
          in_valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each tick result against the oldest prediction
  int stall_left = 0;
  always @(posedge clk) begin
    tick_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          report("tick result with no request waiting");
        end else begin
          e = expected_ticks.pop_front();
          if (out_cpu_process !== e.cpu)
            report($sformatf("cpu_process %0d, want %0d", out_cpu_process, e.cpu));
          if (out_finished !== e.fin)
            report($sformatf("finished %0b, want %0b", out_finished, e.fin));
          if (out_sent_to_io !== e.to_io)
            report($sformatf("sent_to_io %0b, want %0b", out_sent_to_io, e.to_io));
          if (out_all_idle !== e.idle)
            report($sformatf("all_idle %0b, want %0b", out_all_idle, e.idle));
          finishes_seen += e.fin;
          io_sends_seen += e.to_io;
          idle_seen += e.idle;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  // watchdog on accepted traffic
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request or result accepted for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_req(input logic c, input int id, input int b, input int io);
    sched_req_t r;
    r = '{cmd: c, pid: 5'(id), burst: 10'(b), ios: 8'(io)};
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // sender pauses until every expected result is back, then a settle time
  task automatic drain();
    hold_sender = 1'b0;
    while (pending_reqs.size() > 0) @(posedge clk);
    hold_sender = 1'b1;
    #1;
    while (in_valid || expected_ticks.size() > 0) begin
      @(posedge clk);
      #1;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == mfs_pkg::CFG_QUANTUM) quantum_q = val;
    else if (idx == mfs_pkg::CFG_IO_WAIT) io_wait_q = val;
    else aging_q = val[5:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int q, input int w, input int a);
    write_reg(mfs_pkg::CFG_QUANTUM, 8'(q));
    write_reg(mfs_pkg::CFG_IO_WAIT, 8'(w));
    write_reg(mfs_pkg::CFG_AGING_LIMIT, 8'(a));
  endtask

  // one random phase; big field values only when allowed, since those processes never drain
  task automatic random_phase(input int count, input bit heavy);
    int k, id, b, io;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 65) begin
        add_req(mfs_pkg::CMD_TICK, $urandom_range(31), $urandom_range(1023),
                $urandom_range(255));
      end else begin
        k = $urandom_range(99);
        id = (k < 5) ? ($urandom_range(1) ? 0 : $urandom_range(17, 31)) : $urandom_range(1, NPROC);
        k = $urandom_range(99);
        if (k < 5) b = 0;
        else if (k < 80) b = $urandom_range(1, 12);
        else if (heavy && k < 84) b = $urandom_range(512, 1023);
        else b = $urandom_range(13, 100);
        k = $urandom_range(99);
        if (heavy && k < 4) io = $urandom_range(128, 255);
        else io = (k < 85) ? $urandom_range(3) : $urandom_range(4, 20);
        add_req(mfs_pkg::CMD_ARRIVE, id, b, io);
      end
    end
    drain();
  endtask

  initial begin
    quantum_q = mfs_pkg::QUANTUM_DEF;
    io_wait_q = mfs_pkg::IO_WAIT_DEF;
    aging_q = mfs_pkg::AGING_LIMIT_DEF;
    for (int i = 0; i < NPROC; i++) begin
      busy_id[i] = 1'b0;
      fcfs_age[i] = '0;
      progress[i] = '0;
      executed[i] = '0;
    end
    slice_cnt = '0;
    io_clock = -1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset defaults, idle tick, bad ids, duplicate, zero burst, short quantum
    add_req(mfs_pkg::CMD_TICK, 0, 0, 0);
    add_req(mfs_pkg::CMD_ARRIVE, 0, 5, 1);
    add_req(mfs_pkg::CMD_ARRIVE, 17, 5, 1);
    add_req(mfs_pkg::CMD_ARRIVE, 31, 1023, 255);
    add_req(mfs_pkg::CMD_ARRIVE, 16, 0, 0);
    add_req(mfs_pkg::CMD_ARRIVE, 2, 3, 1);
    add_req(mfs_pkg::CMD_ARRIVE, 2, 9, 9);
    add_req(mfs_pkg::CMD_ARRIVE, 1, 1, 0);
    for (int i = 0; i < 12; i++) add_req(mfs_pkg::CMD_TICK, 0, 0, 0);
    drain();

    set_regs(1, 1, 1);
    add_req(mfs_pkg::CMD_ARRIVE, 5, 4, 2);
    add_req(mfs_pkg::CMD_ARRIVE, 6, 2, 1);
    add_req(mfs_pkg::CMD_ARRIVE, 7, 6, 0);
    for (int i = 0; i < 20; i++) add_req(mfs_pkg::CMD_TICK, 0, 0, 0);
    drain();
    random_phase(400, 1'b0);

    set_regs(255, 255, 62);
    random_phase(350, 1'b0);

    set_regs($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 62));
    random_phase(350, 1'b0);

    set_regs(3, 5, 2);
    random_phase(300, 1'b0);

    set_regs(mfs_pkg::QUANTUM_DEF, mfs_pkg::IO_WAIT_DEF, mfs_pkg::AGING_LIMIT_DEF);
    random_phase(300, 1'b1);

    $display("covered %0d ticks and %0d arrivals over six register settings",
             ticks_done, arrivals_done);
    $display("saw %0d completions, %0d moves to i/o and %0d idle ticks",
             finishes_seen, io_sends_seen, idle_seen);
    if (errors == 0 && expected_ticks.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_ticks.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/mfs_pkg.sv
design/mfs_ram.sv
design/multilevel_feedback_scheduler_core.sv
tb/multilevel_feedback_scheduler_core_tb.sv
